[hdl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned COUNT_W       = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_HEAD = 2'd0,
    CMD_PUSH_TAIL = 2'd1,
    CMD_POP_HEAD  = 2'd2,
    CMD_POP_TAIL  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_LOAD
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pop;
  } dp_stat_t;

endpackage

[hdl/deq_if.sv]
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if
// Valid/ready channels for requests and responses of the queue.
// ----------------------------------------------------------------------------
interface deq_req_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::CMD_W-1:0]           cmd;
  logic signed [deq_pkg::VALUE_W-1:0]  item_value;

  modport source (output valid, output cmd, output item_value, input ready);
  modport sink   (input valid, input cmd, input item_value, output ready);
endinterface

interface deq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [deq_pkg::VALUE_W-1:0]  popped_value;
  logic [deq_pkg::STATUS_W-1:0]        status;
  logic [deq_pkg::COUNT_W-1:0]         item_count;

  modport source (output valid, output popped_value, output status, output item_count,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input item_count,
                  output ready);
endinterface

[hdl/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: accept, execute, optional memory read, load output register.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output deq_pkg::ctrl_cmd_t    cmd_o,
  input  deq_pkg::dp_stat_t     stat_i
);

  deq_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deq_pkg::S_IDLE: if (req_valid_i) state_d = deq_pkg::S_EXEC;
      deq_pkg::S_EXEC: state_d = stat_i.is_pop ? deq_pkg::S_READ : deq_pkg::S_LOAD;
      deq_pkg::S_READ: state_d = deq_pkg::S_LOAD;
      deq_pkg::S_LOAD: if (out_free) state_d = deq_pkg::S_IDLE;
      default:         state_d = deq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    out_valid_d = out_valid_q && !rsp_ready_i;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.latch = req_valid_i;
      end
      deq_pkg::S_EXEC: cmd_o.exec = 1'b1;
      deq_pkg::S_READ: ;
      deq_pkg::S_LOAD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign rsp_valid_o = out_valid_q;

endmodule

[hdl/deq_dpath.sv]
// ----------------------------------------------------------------------------
// deq_dpath
// Ring store, head/tail pointers, entry count and output register.
// ----------------------------------------------------------------------------
module deq_dpath #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  deq_pkg::ctrl_cmd_t                  cmd_i,
  output deq_pkg::dp_stat_t                   stat_o,
  input  logic [deq_pkg::CMD_W-1:0]           req_cmd_i,
  input  logic signed [deq_pkg::VALUE_W-1:0]  req_value_i,
  output logic signed [deq_pkg::VALUE_W-1:0]  popped_value_o,
  output logic [deq_pkg::STATUS_W-1:0]        status_o,
  output logic [deq_pkg::COUNT_W-1:0]         item_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [deq_pkg::VALUE_W-1:0] mem [DEPTH];

  deq_pkg::cmd_e                 op_q;
  logic [deq_pkg::VALUE_W-1:0]   val_q;
  logic [AW-1:0]                 head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [deq_pkg::VALUE_W-1:0]   rdata_q;
  deq_pkg::status_e              st_q, st_d;
  logic                          pop_ok_q;

  logic          is_pop, fail, wr_en, rd_en;
  logic [AW-1:0] waddr, raddr, head_inc, head_dec, tail_inc, tail_dec;

  assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
  assign head_dec = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
  assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
  assign tail_dec = (tail_q == '0) ? LAST_IDX : tail_q - AW'(1);

  assign is_pop        = op_q[1];
  assign stat_o.is_pop = is_pop;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    waddr  = tail_q;
    raddr  = head_q;
    wr_en  = 1'b0;
    rd_en  = 1'b0;
    st_d   = deq_pkg::ST_OK;
    fail   = is_pop ? (cnt_q == '0) : (cnt_q == FULL_CNT);
    if (fail) begin
      st_d = is_pop ? deq_pkg::ST_EMPTY : deq_pkg::ST_FULL;
    end else begin
      unique case (op_q)
        deq_pkg::CMD_PUSH_HEAD: begin
          head_d = head_dec;
          waddr  = head_dec;
          wr_en  = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end
        deq_pkg::CMD_PUSH_TAIL: begin
          tail_d = tail_inc;
          waddr  = tail_q;
          wr_en  = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end
        deq_pkg::CMD_POP_HEAD: begin
          head_d = head_inc;
          raddr  = head_q;
          rd_en  = 1'b1;
          cnt_d  = cnt_q - CW'(1);
        end
        deq_pkg::CMD_POP_TAIL: begin
          tail_d = tail_dec;
          raddr  = tail_dec;
          rd_en  = 1'b1;
          cnt_d  = cnt_q - CW'(1);
        end
        default: ;
      endcase
    end
  end

  // ring store
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) mem[waddr] <= val_q;
    if (cmd_i.exec && rd_en) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= deq_pkg::cmd_e'(req_cmd_i);
      val_q <= req_value_i;
    end
    if (cmd_i.exec) begin
      st_q     <= st_d;
      pop_ok_q <= rd_en;
    end
    if (cmd_i.load_out) begin
      popped_value_o <= pop_ok_q ? rdata_q : '0;
      status_o       <= st_q;
      item_count_o   <= deq_pkg::COUNT_W'(cnt_q);
    end
  end

endmodule

[hdl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit values in a ring store.
// ----------------------------------------------------------------------------
// Request channel req_i carries cmd (push head, push tail, pop head, pop tail)
// and item_value (used by pushes only). Response channel rsp_o returns one
// transfer per request: popped_value (zero unless a pop succeeded), status
// (ok, pop on empty, push on full) and item_count after the request, taken
// modulo 32. A failed request leaves the queue unchanged.
// A push passes through the sequencer's execute and output load steps; a pop
// (failed or not) also passes through the registered read of the ring store
// in between. One request is in work at a time; the next request transfer is
// possible in the cycle after the response is loaded.
// A response waiting in the output register does not block the next request;
// a stalled receiver holds that request at the output load step.
// Reset clears the pointers and the count (empty queue) and drops any pending
// response; the ring store needs no clearing.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  deq_req_if.sink    req_i,
  deq_rsp_if.source  rsp_o
);

  deq_pkg::ctrl_cmd_t ctrl_cmd;
  deq_pkg::dp_stat_t  dp_stat;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (ctrl_cmd),
    .stat_i      (dp_stat)
  );

  deq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .stat_o         (dp_stat),
    .req_cmd_i      (req_i.cmd),
    .req_value_i    (req_i.item_value),
    .popped_value_o (rsp_o.popped_value),
    .status_o       (rsp_o.status),
    .item_count_o   (rsp_o.item_count)
  );

endmodule

[hdl/deq_chk.sv]
// ----------------------------------------------------------------------------
// deq_chk
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_chk #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic signed [deq_pkg::VALUE_W-1:0]  popped_value,
  input logic [deq_pkg::STATUS_W-1:0]        status,
  input logic [deq_pkg::COUNT_W-1:0]         item_count
);

  localparam logic [deq_pkg::COUNT_W-1:0] FULL_CNT = deq_pkg::COUNT_W'(DEPTH);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(popped_value) && $stable(status)
      && $stable(item_count))
    else $error("response changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while one is in work");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && status != deq_pkg::ST_OK |-> popped_value == '0)
    else $error("failed request returned a value");

  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && status == deq_pkg::ST_EMPTY |-> item_count == '0)
    else $error("pop on empty with nonzero count");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && status == deq_pkg::ST_FULL |-> item_count == FULL_CNT)
    else $error("push on full with wrong count");

endmodule

bind double_ended_queue deq_chk #(
  .DEPTH (DEPTH)
) u_deq_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid    (req_i.valid),
  .req_ready    (req_i.ready),
  .rsp_valid    (rsp_o.valid),
  .rsp_ready    (rsp_o.ready),
  .popped_value (rsp_o.popped_value),
  .status       (rsp_o.status),
  .item_count   (rsp_o.item_count)
);

[tb/deq_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deq_checker
// Watches the request and response channels of the double-ended queue, keeps
// its own model of the ring store, and checks every response transfer in
// order against the value, status and count that the request must produce.
// ----------------------------------------------------------------------------
module deq_checker #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  deq_req_if          req,
  deq_rsp_if          rsp,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned response_count_o,
  output int unsigned pop_count_o,
  output int unsigned full_count_o,
  output int unsigned empty_count_o
);
  import deq_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped_value;
    status_e                   status;
    logic [COUNT_W-1:0]        item_count;
  } deq_result_t;

  logic signed [VALUE_W-1:0] ring [DEPTH];
  int unsigned               head_ptr;
  int unsigned               tail_ptr;
  int unsigned               fill;
  deq_result_t               awaited_responses [$];

  function automatic void flag_failure(string msg);
    fail_count_o++;
    if (fail_count_o <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  function automatic deq_result_t apply_request(cmd_e op, logic signed [VALUE_W-1:0] value);
    deq_result_t r;
    r.popped_value = '0;
    r.status       = ST_OK;
    case (op)
      CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
          full_count_o++;
        end else if (op == CMD_PUSH_HEAD) begin
          head_ptr       = (head_ptr == 0) ? DEPTH - 1 : head_ptr - 1;
          ring[head_ptr] = value;
          fill++;
        end else begin
          ring[tail_ptr] = value;
          tail_ptr       = (tail_ptr + 1 >= DEPTH) ? 0 : tail_ptr + 1;
          fill++;
        end
      end
      default: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
          empty_count_o++;
        end else if (op == CMD_POP_HEAD) begin
          r.popped_value = ring[head_ptr];
          head_ptr       = (head_ptr + 1 >= DEPTH) ? 0 : head_ptr + 1;
          fill--;
          pop_count_o++;
        end else begin
          tail_ptr       = (tail_ptr == 0) ? DEPTH - 1 : tail_ptr - 1;
          r.popped_value = ring[tail_ptr];
          fill--;
          pop_count_o++;
        end
      end
    endcase
    r.item_count = COUNT_W'(fill);
    return r;
  endfunction

  task automatic check_response();
    deq_result_t want;
    response_count_o++;
    if (awaited_responses.size() == 0) begin
      flag_failure($sformatf("response with no request outstanding (value %0d status %0d count %0d)",
                             rsp.popped_value, rsp.status, rsp.item_count));
      return;
    end
    want = awaited_responses[0];
    awaited_responses.delete(0);
    if (rsp.popped_value !== want.popped_value)
      flag_failure($sformatf("popped_value: expected %0d, got %0d",
                             want.popped_value, rsp.popped_value));
    if (rsp.status !== want.status)
      flag_failure($sformatf("status: expected %0d, got %0d", want.status, rsp.status));
    if (rsp.item_count !== want.item_count)
      flag_failure($sformatf("item_count: expected %0d, got %0d",
                             want.item_count, rsp.item_count));
  endtask

  initial begin
    fail_count_o     = 0;
    response_count_o = 0;
    pop_count_o      = 0;
    full_count_o     = 0;
    empty_count_o    = 0;
    pending_o        = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ptr = 0;
      tail_ptr = 0;
      fill     = 0;
      awaited_responses.delete();
    end else begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) check_response();
      if (req.valid === 1'b1 && req.ready === 1'b1)
        awaited_responses.push_back(apply_request(cmd_e'(req.cmd), req.item_value));
    end
    pending_o = awaited_responses.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the double-ended queue: a short directed pass over
// empty, full and extreme values, then random push/pop segments biased to
// sweep the fill level, with random gaps on both channels and one long
// receiver hold-off. Checking is done by deq_checker.
// ----------------------------------------------------------------------------
module testbench;
  import deq_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEFAULT;
  localparam int unsigned NUM_ITEMS   = 1050;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AFTER  = 150;

  logic        clk_i;
  logic        rst_ni;
  int unsigned sent;
  bit          sender_quiet;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned response_count;
  int unsigned pop_count;
  int unsigned full_count;
  int unsigned empty_count;

  deq_req_if req ();
  deq_rsp_if rsp ();

  double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  deq_checker #(.DEPTH(DEPTH)) checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req              (req),
    .rsp              (rsp),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .response_count_o (response_count),
    .pop_count_o      (pop_count),
    .full_count_o     (full_count),
    .empty_count_o    (empty_count)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned idle_len(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue(cmd_e op, logic signed [VALUE_W-1:0] value);
    int unsigned gap;
    gap = idle_len(sender_quiet);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.cmd        <= op;
    req.item_value <= value;
    @(posedge clk_i);
    while (req.ready !== 1'b1) @(posedge clk_i);
    sent++;
  endtask

  // receiver: random ready pattern plus one long hold-off
  initial begin
    bit          held;
    bit          quiet;
    int unsigned gap;
    held  = 1'b0;
    quiet = 1'b0;
    rsp.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && response_count >= HOLD_AFTER) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if ($urandom_range(0, 15) == 0) quiet = ~quiet;
      gap = idle_len(quiet);
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d responses still outstanding", pending);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned seg_len;
    int unsigned push_bias;
    rst_ni         = 1'b0;
    sent           = 0;
    sender_quiet   = 1'b0;
    req.valid      <= 1'b0;
    req.cmd        <= CMD_PUSH_HEAD;
    req.item_value <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pops on empty, extremes at both ends, fill up, pushes on full
    issue(CMD_POP_HEAD, 32'sh1234_5678);
    issue(CMD_POP_TAIL, '0);
    issue(CMD_PUSH_HEAD, 32'sh7FFF_FFFF);
    issue(CMD_PUSH_TAIL, 32'sh8000_0000);
    issue(CMD_POP_HEAD, '0);
    issue(CMD_POP_TAIL, '0);
    issue(CMD_PUSH_TAIL, '1);
    issue(CMD_POP_TAIL, '0);
    for (int i = 0; i < DEPTH; i++) begin
      if (i % 2 == 0) issue(CMD_PUSH_HEAD, (i % 4 == 0) ? 32'sh8000_0000 : 32'sh5555_5555);
      else            issue(CMD_PUSH_TAIL, (i % 4 == 1) ? 32'sh7FFF_FFFF : 32'shAAAA_AAAA);
    end
    issue(CMD_PUSH_HEAD, 32'sh0BAD_0BAD);
    issue(CMD_PUSH_TAIL, 32'sh0BAD_0BAD);

    // random segments, each leaning toward filling, draining or balance
    while (sent < NUM_ITEMS) begin
      seg_len      = $urandom_range(5, 40);
      sender_quiet = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 2))
        0:       push_bias = 20;
        1:       push_bias = 50;
        default: push_bias = 85;
      endcase
      repeat (seg_len) begin
        if ($urandom_range(0, 99) < push_bias)
          issue($urandom_range(0, 1) ? CMD_PUSH_TAIL : CMD_PUSH_HEAD, pick_value());
        else
          issue($urandom_range(0, 1) ? CMD_POP_TAIL : CMD_POP_HEAD, pick_value());
      end
    end
    req.valid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d requests, %0d responses, %0d successful pops,", sent,
             response_count, pop_count);
    $display("%0d pushes on a full queue and %0d pops on an empty queue.", full_count,
             empty_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
